FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the omni base setpoint checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define OMBSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define OMBSP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ombsp_pkg.sv
// ---------------------------------------------------------------------------
// ombsp_pkg
// Types and constants shared by the omni base position setpoint block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ombsp_pkg;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_LIN_GAIN  = 3'd0,
    REG_ROT_SPEED = 3'd1,
    REG_NORM_FAR  = 3'd2,
    REG_NORM_STOP = 3'd3,
    REG_ANG_FAR   = 3'd4,
    REG_ANG_STOP  = 3'd5
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] LIN_GAIN_RST  = 16'd1000;
  localparam logic [15:0] ROT_SPEED_RST = 16'd1000;
  localparam logic [19:0] NORM_FAR_RST  = 20'd10000;
  localparam logic [15:0] NORM_STOP_RST = 16'd650;
  localparam logic [19:0] ANG_FAR_RST   = 20'd100000;
  localparam logic [19:0] ANG_STOP_RST  = 20'd20000;

  // Speed multipliers applied when far from the target.
  localparam int unsigned LIN_FAR_MULT = 7;
  localparam int unsigned ANG_FAR_MULT = 5;

  // Width of gain times multiplier, and so of each quotient.
  localparam int unsigned QUOT_W = 19;
  localparam int unsigned CNT_W  = $clog2(QUOT_W);

  typedef struct packed {
    logic [15:0] lin_gain;
    logic [15:0] rot_speed;
    logic [19:0] norm_far;
    logic [15:0] norm_stop;
    logic [19:0] ang_far;
    logic [19:0] ang_stop;
  } cfg_t;

  // Request into one multiply-divide lane.
  typedef struct packed {
    logic              start;
    logic [31:0]       mag;
    logic [QUOT_W-1:0] factor;
    logic [32:0]       divisor;
  } lane_req_t;

  // Status out of one multiply-divide lane.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } lane_rsp_t;

endpackage

FILE: hw/rtl/ombsp_in_if.sv
// ---------------------------------------------------------------------------
// ombsp_in_if
// Input channel: load and tick beats with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ombsp_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_angle;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [15:0] delta_angle;

  modport source (
    output valid, mode, target_x, target_y, target_angle,
    output delta_x, delta_y, delta_angle,
    input  ready
  );

  modport sink (
    input  valid, mode, target_x, target_y, target_angle,
    input  delta_x, delta_y, delta_angle,
    output ready
  );
endinterface

FILE: hw/rtl/ombsp_out_if.sv
// ---------------------------------------------------------------------------
// ombsp_out_if
// Result channel: four wheel setpoints and the done flag per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ombsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel0_setpoint;
  logic signed [31:0] wheel1_setpoint;
  logic signed [31:0] wheel2_setpoint;
  logic signed [31:0] wheel3_setpoint;
  logic               move_done;

  modport source (
    output valid, wheel0_setpoint, wheel1_setpoint, wheel2_setpoint,
    output wheel3_setpoint, move_done,
    input  ready
  );

  modport sink (
    input  valid, wheel0_setpoint, wheel1_setpoint, wheel2_setpoint,
    input  wheel3_setpoint, move_done,
    output ready
  );
endinterface

FILE: hw/rtl/omni_base_position_setpoint_top.sv
// ---------------------------------------------------------------------------
// omni_base_position_setpoint_top
// Position-mode setpoint generator for a four-wheel omni base.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat content
//  in_ch    sink       valid/ready          mode, targets, odometry deltas
//  out_ch   source     valid/ready          four wheel setpoints, move_done
//  cfg      slave      psel/penable, pready six speed and threshold registers
//
//  A load beat is absorbed without leaving the idle state and gives no result.
//  A tick beat passes the norm, scale, run and mix states before the next ready;
//  the run state waits on the two bit-serial lanes (19 shift-add steps and 19 divide steps each).
//  The result sits in an output register; a stalled sink holds only the mix
//  step, and the block waits in that step until the register is free.
//  Synchronous active-low reset; there is no clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module omni_base_position_setpoint_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ombsp_in_if.sink                      in_ch,
  ombsp_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ombsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ombsp_pkg::DATA_W-1:0]  pwdata,
  output logic [ombsp_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned QW = ombsp_pkg::QUOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SCALE,
    S_RUN,
    S_MIX
  } state_t;

  ombsp_pkg::cfg_t       cfg;
  ombsp_pkg::lane_req_t  req_x, req_y;
  ombsp_pkg::lane_rsp_t  rsp_x, rsp_y;

  state_t        state_r, state_nxt;
  logic [31:0]   rem_x_r, rem_x_nxt;
  logic [31:0]   rem_y_r, rem_y_nxt;
  logic [31:0]   rem_a_r, rem_a_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   mag_x_r, mag_x_nxt;
  logic [31:0]   mag_y_r, mag_y_nxt;
  logic [31:0]   abs_a_r, abs_a_nxt;
  logic [32:0]   norm_r, norm_nxt;
  logic          lin_en_r, lin_en_nxt;
  logic [QW-1:0] factor_r, factor_nxt;
  logic [QW:0]   rot_r, rot_nxt;
  logic          start_r, start_nxt;
  logic [31:0]   w0_r, w0_nxt;
  logic [31:0]   w1_r, w1_nxt;
  logic [31:0]   w2_r, w2_nxt;
  logic [31:0]   w3_r, w3_nxt;
  logic          mdone_r, mdone_nxt;
  logic          oval_r, oval_nxt;

  logic          accept;
  logic          lin_far;
  logic          ang_far;
  logic          ang_en;
  logic [QW-1:0] gain_ext;
  logic [QW-1:0] rspd_ext;
  logic [QW-1:0] rot_mag;
  logic [QW:0]   spd_x;
  logic [QW:0]   spd_y;
  logic [QW+1:0] sum0, sum1, sum2, sum3;

  assign pready = 1'b1;

  ombsp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Two lanes run in lockstep, one for X and one for Y.
  assign req_x.start   = start_r;
  assign req_x.mag     = mag_x_r;
  assign req_x.factor  = factor_r;
  assign req_x.divisor = norm_r;
  assign req_y.start   = start_r;
  assign req_y.mag     = mag_y_r;
  assign req_y.factor  = factor_r;
  assign req_y.divisor = norm_r;

  ombsp_muldiv u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_x),
    .rsp   (rsp_x)
  );

  ombsp_muldiv u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_y),
    .rsp   (rsp_y)
  );

  // Handshake and port outputs.
  assign in_ch.ready            = (state_r == S_IDLE);
  assign accept                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = oval_r;
  assign out_ch.wheel0_setpoint = w0_r;
  assign out_ch.wheel1_setpoint = w1_r;
  assign out_ch.wheel2_setpoint = w2_r;
  assign out_ch.wheel3_setpoint = w3_r;
  assign out_ch.move_done       = mdone_r;

  // Threshold tests and speed factors from the registered norms.
  assign lin_far  = norm_r > {13'd0, cfg.norm_far};
  assign ang_far  = abs_a_r > {12'd0, cfg.ang_far};
  assign ang_en   = abs_a_r > {12'd0, cfg.ang_stop};
  assign gain_ext = {{(QW-16){1'b0}}, cfg.lin_gain};
  assign rspd_ext = {{(QW-16){1'b0}}, cfg.rot_speed};
  assign rot_mag  = ang_far ? QW'(rspd_ext * ombsp_pkg::ANG_FAR_MULT) : rspd_ext;

  // Signed linear speeds from the unsigned quotients.
  assign spd_x = !lin_en_r ? '0 :
                 rem_x_r[31] ? (~{1'b0, rsp_x.quot} + 1'b1) : {1'b0, rsp_x.quot};
  assign spd_y = !lin_en_r ? '0 :
                 rem_y_r[31] ? (~{1'b0, rsp_y.quot} + 1'b1) : {1'b0, rsp_y.quot};

  // Wheel mix. The sums are 21 bits wide and are sign extended to 32 bits.
  assign sum0 = {spd_y[QW], spd_y} + {rot_r[QW], rot_r};
  assign sum1 = {rot_r[QW], rot_r} - {spd_x[QW], spd_x};
  assign sum2 = {rot_r[QW], rot_r} - {spd_y[QW], spd_y};
  assign sum3 = {spd_x[QW], spd_x} + {rot_r[QW], rot_r};

  always_comb begin
    state_nxt  = state_r;
    rem_x_nxt  = rem_x_r;
    rem_y_nxt  = rem_y_r;
    rem_a_nxt  = rem_a_r;
    done_nxt   = done_r;
    mag_x_nxt  = mag_x_r;
    mag_y_nxt  = mag_y_r;
    abs_a_nxt  = abs_a_r;
    norm_nxt   = norm_r;
    lin_en_nxt = lin_en_r;
    factor_nxt = factor_r;
    rot_nxt    = rot_r;
    start_nxt  = 1'b0;
    w0_nxt     = w0_r;
    w1_nxt     = w1_r;
    w2_nxt     = w2_r;
    w3_nxt     = w3_r;
    mdone_nxt  = mdone_r;
    oval_nxt   = oval_r;

    // The output register frees once its beat is taken.
    if (oval_r && out_ch.ready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.mode) begin
            rem_x_nxt = in_ch.target_x;
            rem_y_nxt = in_ch.target_y;
            rem_a_nxt = in_ch.target_angle;
            done_nxt  = 1'b0;
          end else begin
            // X and Y deltas count only while a linear move remains.
            if ((rem_x_r != 32'd0) || (rem_y_r != 32'd0)) begin
              rem_x_nxt = rem_x_r - {{16{in_ch.delta_x[15]}}, in_ch.delta_x};
              rem_y_nxt = rem_y_r - {{16{in_ch.delta_y[15]}}, in_ch.delta_y};
            end
            rem_a_nxt = rem_a_r - {{16{in_ch.delta_angle[15]}}, in_ch.delta_angle};
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        mag_x_nxt = rem_x_r[31] ? (~rem_x_r + 32'd1) : rem_x_r;
        mag_y_nxt = rem_y_r[31] ? (~rem_y_r + 32'd1) : rem_y_r;
        abs_a_nxt = rem_a_r[31] ? (~rem_a_r + 32'd1) : rem_a_r;
        norm_nxt  = {1'b0, mag_x_nxt} + {1'b0, mag_y_nxt};
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        lin_en_nxt = norm_r > {17'd0, cfg.norm_stop};
        factor_nxt = lin_far ? QW'(gain_ext * ombsp_pkg::LIN_FAR_MULT) : gain_ext;
        if (!ang_en) begin
          rot_nxt = '0;
        end else if (rem_a_r[31]) begin
          rot_nxt = ~{1'b0, rot_mag} + 1'b1;
        end else begin
          rot_nxt = {1'b0, rot_mag};
        end
        // Done latches until the next load.
        if ((norm_r < {17'd0, cfg.norm_stop}) && (abs_a_r < {12'd0, cfg.ang_stop})) begin
          done_nxt = 1'b1;
        end
        start_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (rsp_x.done && rsp_y.done) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (!oval_r || out_ch.ready) begin
          w0_nxt    = {{(32-QW-2){sum0[QW+1]}}, sum0};
          w1_nxt    = {{(32-QW-2){sum1[QW+1]}}, sum1};
          w2_nxt    = {{(32-QW-2){sum2[QW+1]}}, sum2};
          w3_nxt    = {{(32-QW-2){sum3[QW+1]}}, sum3};
          mdone_nxt = done_r;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_x_r  <= mag_x_nxt;
    mag_y_r  <= mag_y_nxt;
    abs_a_r  <= abs_a_nxt;
    norm_r   <= norm_nxt;
    lin_en_r <= lin_en_nxt;
    factor_r <= factor_nxt;
    rot_r    <= rot_nxt;
    w0_r     <= w0_nxt;
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    w3_r     <= w3_nxt;
    mdone_r  <= mdone_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      rem_x_r <= '0;
      rem_y_r <= '0;
      rem_a_r <= '0;
      done_r  <= 1'b0;
      start_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      rem_a_r <= rem_a_nxt;
      done_r  <= done_nxt;
      start_r <= start_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

FILE: hw/rtl/ombsp_cfg_regs.sv
// ---------------------------------------------------------------------------
// ombsp_cfg_regs
// APB-style register file holding the six speed and threshold settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ombsp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ombsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ombsp_pkg::DATA_W-1:0]  pwdata,
  output logic [ombsp_pkg::DATA_W-1:0]  prdata,
  output ombsp_pkg::cfg_t               cfg
);

  ombsp_pkg::cfg_t      cfg_r;
  ombsp_pkg::cfg_t      cfg_nxt;
  ombsp_pkg::reg_idx_t  idx;
  logic                 wr_en;

  assign idx   = ombsp_pkg::reg_idx_t'(paddr[ombsp_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // Write decode; unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ombsp_pkg::REG_LIN_GAIN:  cfg_nxt.lin_gain  = pwdata[15:0];
        ombsp_pkg::REG_ROT_SPEED: cfg_nxt.rot_speed = pwdata[15:0];
        ombsp_pkg::REG_NORM_FAR:  cfg_nxt.norm_far  = pwdata[19:0];
        ombsp_pkg::REG_NORM_STOP: cfg_nxt.norm_stop = pwdata[15:0];
        ombsp_pkg::REG_ANG_FAR:   cfg_nxt.ang_far   = pwdata[19:0];
        ombsp_pkg::REG_ANG_STOP:  cfg_nxt.ang_stop  = pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer, zero extended to the bus width.
  always_comb begin
    case (idx)
      ombsp_pkg::REG_LIN_GAIN:  prdata = {16'd0, cfg_r.lin_gain};
      ombsp_pkg::REG_ROT_SPEED: prdata = {16'd0, cfg_r.rot_speed};
      ombsp_pkg::REG_NORM_FAR:  prdata = {12'd0, cfg_r.norm_far};
      ombsp_pkg::REG_NORM_STOP: prdata = {16'd0, cfg_r.norm_stop};
      ombsp_pkg::REG_ANG_FAR:   prdata = {12'd0, cfg_r.ang_far};
      ombsp_pkg::REG_ANG_STOP:  prdata = {12'd0, cfg_r.ang_stop};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lin_gain  <= ombsp_pkg::LIN_GAIN_RST;
      cfg_r.rot_speed <= ombsp_pkg::ROT_SPEED_RST;
      cfg_r.norm_far  <= ombsp_pkg::NORM_FAR_RST;
      cfg_r.norm_stop <= ombsp_pkg::NORM_STOP_RST;
      cfg_r.ang_far   <= ombsp_pkg::ANG_FAR_RST;
      cfg_r.ang_stop  <= ombsp_pkg::ANG_STOP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/ombsp_muldiv.sv
// ---------------------------------------------------------------------------
// ombsp_muldiv
// Bit-serial lane: magnitude times factor, then divided by the L1 norm.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ombsp_muldiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ombsp_pkg::lane_req_t  req,
  output ombsp_pkg::lane_rsp_t  rsp
);

  localparam int unsigned QW = ombsp_pkg::QUOT_W;
  localparam int unsigned CW = ombsp_pkg::CNT_W;
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV
  } lane_state_t;

  lane_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic [32:0]   div_r, div_nxt;
  // hi holds the upper product bits, later the partial remainder.
  logic [32:0]   hi_r, hi_nxt;
  // lo holds the factor bits, then the low product bits, then the quotient.
  logic [QW-1:0] lo_r, lo_nxt;

  logic [32:0]   sum;
  logic [32:0]   acc;
  logic [33:0]   rem_sh;
  logic [34:0]   diff;
  logic          ge;

  // Shift-add step: the partial product never reaches bit 32.
  assign sum    = hi_r + {1'b0, mag_r};
  assign acc    = lo_r[0] ? sum : hi_r;
  // Restoring division step: bring down one product bit and trial subtract.
  assign rem_sh = {hi_r, lo_r[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge     = !diff[34];

  assign rsp.done = done_r;
  assign rsp.quot = lo_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    mag_nxt   = mag_r;
    div_nxt   = div_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    case (state_r)
      L_IDLE: begin
        if (req.start) begin
          mag_nxt   = req.mag;
          div_nxt   = req.divisor;
          hi_nxt    = '0;
          lo_nxt    = req.factor;
          cnt_nxt   = '0;
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        hi_nxt = {1'b0, acc[32:1]};
        lo_nxt = {acc[0], lo_r[QW-1:1]};
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = L_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      L_DIV: begin
        hi_nxt = ge ? diff[32:0] : rem_sh[32:0];
        lo_nxt = {lo_r[QW-2:0], ge};
        if (cnt_r == LAST) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    div_r <= div_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

FILE: hw/rtl/ombsp_checker.sv
// ---------------------------------------------------------------------------
// ombsp_checker
// Port-level checks on the setpoint block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ombsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] wheel0,
  input logic [31:0] wheel1,
  input logic [31:0] wheel2,
  input logic [31:0] wheel3,
  input logic        move_done
);

  logic [128:0] out_beat;
  logic         out_stall;
  logic         tick_beat;
  logic         load_beat;

  // Whole result payload, and the handshake conditions the checks start from.
  assign out_beat  = {wheel0, wheel1, wheel2, wheel3, move_done};
  assign out_stall = out_valid && !out_ready;
  assign tick_beat = in_valid && in_ready && !in_mode;
  assign load_beat = in_valid && in_ready && in_mode;

  // A result beat that is not taken stays offered and unchanged.
`OMBSP_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_beat), "stalled beat changed")

  // A tick beat occupies the block, so ready drops straight after it.
`OMBSP_ASSERT(a_tick_busy, clk, rst_n, tick_beat |=> !in_ready, "ready held after a tick beat")

  // A load beat is absorbed at once and the block stays ready.
`OMBSP_ASSERT(a_load_ready, clk, rst_n, load_beat |=> in_ready, "ready dropped after a load beat")

  // Reset leaves no result pending and the input ready.
`OMBSP_ASSERT_RST(a_reset_state, clk, !rst_n |=> (!out_valid && in_ready), "bad state after reset")

endmodule

bind omni_base_position_setpoint_top ombsp_checker u_ombsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .wheel0    (out_ch.wheel0_setpoint),
  .wheel1    (out_ch.wheel1_setpoint),
  .wheel2    (out_ch.wheel2_setpoint),
  .wheel3    (out_ch.wheel3_setpoint),
  .move_done (out_ch.move_done)
);
